[rtl/dfq_pkg.sv]
// dfq_pkg: shared types and codes for the duplicate-rejecting queue.
// No dependencies; imported by dfq_cell, dedup_fifo_queue_top and the testbench.
`timescale 1ns / 1ps

package dfq_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned CountW = 5;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [DataW-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DataW-1:0]  removed_value;
		logic signed [DataW-1:0]  head_value;
		logic signed [DataW-1:0]  tail_value;
		logic [CountW-1:0]        element_count;
	} out_word_t;

	// Qualified operation broadcast to every cell.
	typedef struct packed {
		logic push;  // append at first free cell
		logic pop;   // shift whole row one cell toward head
	} cell_ctrl_t;

endpackage

[rtl/dfq_cell.sv]
// dfq_cell: one queue slot; holds a value and its valid bit, compares with
// the incoming word and takes its neighbor's contents on a pop. Uses dfq_pkg.
`timescale 1ns / 1ps

module dfq_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dfq_pkg::cell_ctrl_t              ctrl,
	input  logic signed [dfq_pkg::DataW-1:0] in_value,
	input  logic                             prev_valid,
	input  logic signed [dfq_pkg::DataW-1:0] next_value,
	input  logic                             next_valid,
	output logic signed [dfq_pkg::DataW-1:0] value_q,
	output logic                             valid_q,
	output logic                             match
);
	import dfq_pkg::*;

	logic take_push;

	// first free slot: previous one occupied, this one not
	assign take_push = ctrl.push && prev_valid && !valid_q;
	assign match     = valid_q && (value_q == in_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end else if (take_push) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			value_q <= next_value;
		end else if (take_push) begin
			value_q <= in_value;
		end
	end

endmodule

[rtl/dedup_fifo_queue_top.sv]
// dedup_fifo_queue_top: FIFO of signed 32-bit words that refuses duplicates.
// Result word and done strobe are registered: they appear the cycle after start.
// Throughput 1 word per cycle; busy stays low, the cell row absorbs every op.
// Duplicate search is one compare per cell, ORed across the row.
// Reset (arst_n low): queue empty, no strobe; slot data is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per result.
`timescale 1ns / 1ps

module dedup_fifo_queue_top #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  dfq_pkg::in_word_t  cmd,
	output logic               done,
	output dfq_pkg::out_word_t result
);
	import dfq_pkg::*;

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// row of cells; cell 0 is the head
	logic signed [DataW-1:0] cell_value [QUEUE_DEPTH];
	logic                    cell_valid [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]  cell_match;

	cell_ctrl_t ctrl;

	logic [CW-1:0]           count_q;
	logic [CW-1:0]           count_nxt;
	logic signed [DataW-1:0] tail_q;
	logic signed [DataW-1:0] tail_nxt;
	logic signed [DataW-1:0] head_nxt;
	logic signed [DataW-1:0] removed;
	logic [1:0]              status;
	logic                    is_dup;
	logic                    is_full;
	logic                    is_empty;
	logic [CW+CountW-1:0]    count_ext;

	out_word_t result_q;
	logic      done_q;

	// every word is taken on arrival
	assign busy = 1'b0;

	assign is_dup   = |cell_match;
	assign is_full  = cell_valid[QUEUE_DEPTH-1];
	assign is_empty = !cell_valid[0];

	// decode the op; duplicate check wins over full
	always_comb begin
		ctrl    = '0;
		status  = ST_OK;
		removed = '0;
		unique case (cmd.mode)
			MODE_INSERT: begin
				if (is_dup) begin
					status = ST_DUP;
				end else if (is_full) begin
					status = ST_FULL;
				end else begin
					ctrl.push = start;
				end
			end
			MODE_REMOVE: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					ctrl.pop = start;
					removed  = cell_value[0];
				end
			end
			default: begin
				// query, and the unused code behaves as query
			end
		endcase
	end

	// post-step head, tail and count; tail and count tracked without indexing the row
	always_comb begin
		count_nxt = count_q;
		tail_nxt  = tail_q;
		head_nxt  = cell_valid[0] ? cell_value[0] : '0;
		if (ctrl.push) begin
			count_nxt = count_q + CW'(1);
			tail_nxt  = cmd.value;
			if (is_empty) begin
				head_nxt = cmd.value;
			end
		end else if (ctrl.pop) begin
			count_nxt = count_q - CW'(1);
			if (count_q == CW'(1)) begin
				tail_nxt = '0;
				head_nxt = '0;
			end else begin
				head_nxt = cell_value[(QUEUE_DEPTH > 1) ? 1 : 0];
			end
		end
	end

	assign count_ext = {{CountW{1'b0}}, count_nxt};

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic                    prev_v;
			logic                    next_v;
			logic signed [DataW-1:0] next_d;
			if (gi == 0) begin : g_first
				assign prev_v = 1'b1;
			end else begin : g_mid
				assign prev_v = cell_valid[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign next_v = 1'b0;
				assign next_d = '0;
			end else begin : g_inner
				assign next_v = cell_valid[gi+1];
				assign next_d = cell_value[gi+1];
			end
			dfq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.in_value   (cmd.value),
				.prev_valid (prev_v),
				.next_value (next_d),
				.next_valid (next_v),
				.value_q    (cell_value[gi]),
				.valid_q    (cell_valid[gi]),
				.match      (cell_match[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tail_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= start;
			if (start) begin
				count_q <= count_nxt;
				tail_q  <= tail_nxt;
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (start) begin
			result_q.status        <= status;
			result_q.removed_value <= removed;
			result_q.head_value    <= head_nxt;
			result_q.tail_value    <= tail_nxt;
			result_q.element_count <= count_ext[CountW-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[verif/testbench.sv]
// testbench: self-checking bench for dedup_fifo_queue_top, driven by start/busy commands.
// Depends on dfq_pkg and dedup_fifo_queue_top; holds a shadow copy of the queue
// and checks every done-strobed result word field by field.
`timescale 1ns / 1ps

module testbench;
	import dfq_pkg::*;

	localparam int unsigned DEPTH      = 16;
	// mode code 3 has no package name; the block treats it as a query
	localparam logic [1:0]  MODE_SPARE = 2'd3;
	localparam int unsigned POOL_N     = 24;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	logic      done;
	in_word_t  cmd;
	out_word_t result;

	// shadow of the stored values, head at index 0
	logic signed [DataW-1:0] shadow_entries[$];
	// result words still owed by the block, oldest first
	out_word_t               pending_results[$];
	// small value pool so that duplicates come up often
	logic signed [DataW-1:0] value_pool[POOL_N];
	int unsigned             err_count;
	// when set, the sender issues words back to back
	bit                      gapless;

	dedup_fifo_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Expected result word for one accepted command; updates the shadow queue.
	// Duplicate check wins over the full check, as in the block.
	function automatic out_word_t predict_queue_word(in_word_t w);
		out_word_t r;
		logic      dup;
		r        = '0;
		r.status = ST_OK;
		dup      = 1'b0;
		case (w.mode)
			MODE_INSERT: begin
				foreach (shadow_entries[i])
					if (shadow_entries[i] == w.value)
						dup = 1'b1;
				if (dup)
					r.status = ST_DUP;
				else if (shadow_entries.size() >= DEPTH)
					r.status = ST_FULL;
				else
					shadow_entries.push_back(w.value);
			end
			MODE_REMOVE: begin
				if (shadow_entries.size() == 0)
					r.status = ST_EMPTY;
				else
					r.removed_value = shadow_entries.pop_front();
			end
			default: ; // query and spare code change nothing
		endcase
		if (shadow_entries.size() > 0) begin
			r.head_value = shadow_entries[0];
			r.tail_value = shadow_entries[$];
		end
		r.element_count = CountW'(shadow_entries.size());
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < 50)
			$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		err_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// One command word: present at the falling edge, held until a rising edge
	// sees busy low. start is left high; the next send or a pause decides.
	task automatic send_word(input logic [1:0] mode, input logic signed [DataW-1:0] value);
		in_word_t w;
		w.mode  = mode;
		w.value = value;
		@(negedge clk);
		start <= 1'b1;
		cmd   <= w;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_results.push_back(predict_queue_word(w));
	endtask

	// Idle cycles: start low, junk on cmd to show it is ignored.
	task automatic pause(input int unsigned n);
		in_word_t junk;
		repeat (n) begin
			junk.mode  = 2'($urandom_range(3));
			junk.value = $urandom;
			@(negedge clk);
			start <= 1'b0;
			cmd   <= junk;
		end
	endtask

	// Mostly short gaps, a few long ones, none in gapless stretches.
	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(99);
		if (gapless || p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 6);
	endfunction

	function automatic logic signed [DataW-1:0] pick_value();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 30 && shadow_entries.size() > 0)
			return shadow_entries[$urandom_range(shadow_entries.size() - 1)];
		if (p < 65)
			return value_pool[$urandom_range(POOL_N - 1)];
		return $urandom;
	endfunction

	// Result checker: every done strobe is matched against the oldest expectation.
	always @(posedge clk) begin : check_results
		out_word_t want;
		if (arst_n && done !== 1'b0) begin
			if (done !== 1'b1 || pending_results.size() == 0) begin
				report_mismatch("done with no word expected", 32'(done), 32'd0);
			end else begin
				want = pending_results.pop_front();
				check_field("status", result.status, want.status);
				check_field("removed_value", result.removed_value, want.removed_value);
				check_field("head_value", result.head_value, want.head_value);
				check_field("tail_value", result.tail_value, want.tail_value);
				check_field("element_count", result.element_count, want.element_count);
			end
		end
	end

	// Empty-queue cases, value extremes, duplicates at head and in the middle,
	// the spare mode code, then a drain past empty.
	task automatic test_directed();
		send_word(MODE_QUERY, 32'sh1234_5678);
		send_word(MODE_REMOVE, 32'sh0BAD_F00D);
		pause(pick_gap());
		send_word(MODE_INSERT, 32'sh0000_0000);
		send_word(MODE_INSERT, 32'sh8000_0000);
		send_word(MODE_INSERT, 32'sh7FFF_FFFF);
		pause(pick_gap());
		send_word(MODE_INSERT, -32'sd1);
		send_word(MODE_INSERT, 32'sd1);
		send_word(MODE_INSERT, -32'sd1);
		send_word(MODE_INSERT, 32'sh0000_0000);
		send_word(MODE_SPARE, 32'shFFFF_FFFF);
		send_word(MODE_QUERY, 32'sh7FFF_FFFF);
		pause(pick_gap());
		repeat (6)
			send_word(MODE_REMOVE, $urandom);
		send_word(MODE_INSERT, 32'sh8000_0000);
		send_word(MODE_REMOVE, 32'sh0);
		pause(pick_gap());
	endtask

	// Fill to depth with fresh values, hit the full case with a held value
	// (duplicate wins) and a new one, then drain one past empty.
	task automatic test_fill_and_overflow(input int unsigned rounds);
		repeat (rounds) begin
			gapless = ($urandom_range(1) == 0);
			while (shadow_entries.size() < DEPTH) begin
				send_word(MODE_INSERT, $urandom);
				pause(pick_gap());
			end
			send_word(MODE_INSERT, shadow_entries[$urandom_range(DEPTH - 1)]);
			send_word(MODE_INSERT, shadow_entries[DEPTH - 1]);
			send_word(MODE_INSERT, $urandom);
			send_word(MODE_QUERY, $urandom);
			while (shadow_entries.size() > 0) begin
				send_word(MODE_REMOVE, $urandom);
				pause(pick_gap());
			end
			send_word(MODE_REMOVE, $urandom);
		end
		gapless = 1'b0;
	endtask

	// Random traffic in phases of fill-heavy, balanced and drain-heavy mixes,
	// some phases without gaps.
	task automatic test_random_traffic(input int unsigned n);
		int unsigned insert_pct;
		int unsigned p;
		logic [1:0]  mode;
		insert_pct = 50;
		for (int unsigned k = 0; k < n; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(2))
					0:       insert_pct = 85;
					1:       insert_pct = 50;
					default: insert_pct = 20;
				endcase
				gapless = ($urandom_range(3) == 0);
			end
			p = $urandom_range(99);
			if (p < 3)
				mode = MODE_SPARE;
			else if (p < 10)
				mode = MODE_QUERY;
			else if ($urandom_range(99) < insert_pct)
				mode = MODE_INSERT;
			else
				mode = MODE_REMOVE;
			send_word(mode, pick_value());
			pause(pick_gap());
		end
		gapless = 1'b0;
	endtask

	initial begin
		int unsigned spins;
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		err_count = 0;
		gapless   = 1'b0;
		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7FFF_FFFF;
		value_pool[2] = 32'sh0000_0000;
		value_pool[3] = -32'sd1;
		for (int unsigned i = 4; i < POOL_N; i++)
			value_pool[i] = $urandom;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fill_and_overflow(2);
		test_random_traffic(770);
		test_fill_and_overflow(1);
		pause(1);

		// results are registered; allow a margin, then flag anything still owed
		spins = 0;
		while (pending_results.size() != 0 && spins < 50) begin
			@(posedge clk);
			spins++;
		end
		repeat (4)
			@(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("result words never seen", pending_results.size(), 32'd0);

		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (about 900 words, all with the longest gaps).
	initial begin
		#(5_000_000);
		$display("FAILURE");
		$finish;
	end

endmodule
